FILE: hw/rtl/c8_pkg.sv
// Shared types and constants of the CHIP-8 instruction core.
package c8_pkg;

    localparam int ADDR_W = 12;
    localparam int MEM_BYTES = 4096;
    localparam int SCR_W = 64;
    localparam int SCR_H = 32;
    localparam int ROW_W = 5;

    localparam logic [ADDR_W-1:0] START_PC = 12'h200;

    localparam logic [1:0] K_LOAD = 2'd0;
    localparam logic [1:0] K_STEP = 2'd1;
    localparam logic [1:0] K_PIX  = 2'd2;
    localparam logic [1:0] K_REG  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LOOP   = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;
    localparam logic [1:0] ST_HALTED = 2'd3;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_SETI = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [7:0] NN_CLS  = 8'hE0;
    localparam logic [7:0] NN_RET  = 8'hEE;
    localparam logic [7:0] NN_ADDI = 8'h1E;
    localparam logic [7:0] NN_BCD  = 8'h33;
    localparam logic [7:0] NN_DUMP = 8'h55;
    localparam logic [7:0] NN_FILL = 8'h65;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [3:0] REG_F = 4'hF;

    typedef enum logic [3:0] {
        S_IDLE, S_RDW, S_F1, S_F2, S_R1, S_R2, S_EX, S_FLG,
        S_DR, S_DW, S_DF, S_BCD, S_STR, S_STW, S_LDR, S_LDW
    } t_state;

endpackage

FILE: hw/rtl/c8_ram.sv
// Synchronous memory with one write port and one registered read port.
module c8_ram #(
    parameter int W = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/chip8_instruction_core_unit.sv
// CHIP-8 instruction core top level: sequencer around program, register, screen and stack RAMs.
//
// A request on the input channel carries a kind, an address and a data byte.
// Load requests write one program memory byte, step requests fetch and
// execute the opcode at the program counter, and read requests return one
// screen pixel or one general register. Every request yields exactly one
// result on the output channel with the program counter, the executed
// opcode, a status code and the read value.
// A load is written at once, a read passes a wait state and a step runs
// through the fetch, operand read and execute sequence. A sprite draw adds
// a read and a write per row, a dump or fill a read and a write per
// register and BCD one write per digit, all bound by the single RAM port.
// One request is in flight at a time; the next is taken once the result
// register is empty. When the receiver stalls, the result holds and the
// input stalls until it is taken.
// Reset clears the registers, screen and stack at once through per-entry
// valid bits, sets the program counter to 0x200 and clears the halt flag.
// Program memory holds no reset value and must be loaded before it is run.
module chip8_instruction_core_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [c8_pkg::ADDR_W-1:0] i_address,
    input  logic [7:0]            i_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [c8_pkg::ADDR_W-1:0] o_next_pc,
    output logic [15:0]           o_opcode,
    output logic [1:0]            o_status,
    output logic [7:0]            o_read_value
);
    import c8_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_MAX = SPW'(STACK_DEPTH - 1);

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_pc, n_pc, r_i, n_i;
    logic [SPW-1:0] r_sp, n_sp;
    logic r_halt, n_halt, r_quit;
    logic [1:0] r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [15:0] r_op, n_op;
    logic [7:0] r_vx, n_vx, r_vy, n_vy, r_flag, n_flag;
    logic [3:0] r_cnt, n_cnt;
    logic r_hit, n_hit;
    logic [15:0] r_vvld, n_vvld;
    logic [SCR_H-1:0] r_svld, n_svld;
    logic [STACK_DEPTH-1:0] r_kvld, n_kvld;
    logic r_vrv, r_srv, r_krv;
    logic r_ov;
    logic [ADDR_W-1:0] r_o_pc, n_o_pc;
    logic [15:0] r_o_op, n_o_op;
    logic [1:0] r_o_st, n_o_st;
    logic [7:0] r_o_rv, n_o_rv;
    logic fin, accept;

    logic pm_we;
    logic [ADDR_W-1:0] pm_wa, pm_ra;
    logic [7:0] pm_wd, pm_rd;
    logic vr_we;
    logic [3:0] vr_wa, vr_ra;
    logic [7:0] vr_wd, vr_rd;
    logic sc_we;
    logic [ROW_W-1:0] sc_wa, sc_ra;
    logic [SCR_W-1:0] sc_wd, sc_rd;
    logic sk_we;
    logic [SPW-1:0] sk_wa, sk_ra;
    logic [ADDR_W-1:0] sk_wd, sk_rd;

    logic [3:0] top, ox, oy, on;
    logic [7:0] nn;
    logic [ADDR_W-1:0] nnn, pc2, pc4;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic [7:0] vval;
    logic [SCR_W-1:0] sval, mask, sprite64;
    logic [2*SCR_W-1:0] rot;
    logic [7:0] sprite_rev;
    logic [8:0] sum9;
    logic [7:0] hund, rem, tens, ones;
    logic [15:0] prod;
    logic [ROW_W-1:0] draw_row;
    logic [ADDR_W-1:0] i_off;

    c8_ram #(.W(8), .DEPTH(MEM_BYTES)) u_pmem (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_wa), .i_wdata(pm_wd),
        .i_raddr(pm_ra), .o_rdata(pm_rd)
    );
    c8_ram #(.W(8), .DEPTH(16)) u_vreg (
        .i_clk(i_clk), .i_we(vr_we), .i_waddr(vr_wa), .i_wdata(vr_wd),
        .i_raddr(vr_ra), .o_rdata(vr_rd)
    );
    c8_ram #(.W(SCR_W), .DEPTH(SCR_H)) u_screen (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_wa), .i_wdata(sc_wd),
        .i_raddr(sc_ra), .o_rdata(sc_rd)
    );
    c8_ram #(.W(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(sk_we), .i_waddr(sk_wa), .i_wdata(sk_wd),
        .i_raddr(sk_ra), .o_rdata(sk_rd)
    );

    assign o_in_stall = !((r_state == S_IDLE) && !r_ov);
    assign accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_next_pc = r_o_pc;
    assign o_opcode = r_o_op;
    assign o_status = r_o_st;
    assign o_read_value = r_o_rv;

    assign top = r_op[15:12];
    assign ox = r_op[11:8];
    assign oy = r_op[7:4];
    assign on = r_op[3:0];
    assign nn = r_op[7:0];
    assign nnn = r_op[11:0];
    assign pc2 = r_pc + 12'd2;
    assign pc4 = r_pc + 12'd4;
    assign sp_inc = (r_sp == SP_MAX) ? '0 : r_sp + SPW'(1);
    assign sp_dec = (r_sp == '0) ? SP_MAX : r_sp - SPW'(1);
    assign vval = r_vrv ? vr_rd : 8'h00;
    assign sval = r_srv ? sc_rd : '0;
    assign draw_row = r_vy[ROW_W-1:0] + ROW_W'(r_cnt);
    assign i_off = r_i + ADDR_W'(r_cnt);
    assign sum9 = {1'b0, r_vx} + {1'b0, r_vy};

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            sprite_rev[b] = pm_rd[7-b];
        end
        sprite64 = {{(SCR_W-8){1'b0}}, sprite_rev};
        rot = {sprite64, sprite64} << r_vx[5:0];
        mask = rot[2*SCR_W-1:SCR_W];
        if (r_vx >= 8'd200) begin
            hund = 8'd2;
        end else if (r_vx >= 8'd100) begin
            hund = 8'd1;
        end else begin
            hund = 8'd0;
        end
        rem = r_vx - 8'(hund * 8'd100);
        prod = {8'h00, rem} * 16'd205;
        tens = {3'b000, prod[15:11]};
        ones = rem - 8'(tens * 8'd10);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_kind == K_PIX) || (i_kind == K_REG)) begin
                        n_state = S_RDW;
                    end else if ((i_kind == K_STEP) && !r_halt) begin
                        n_state = S_F1;
                    end
                end
            end
            S_RDW: n_state = S_IDLE;
            S_F1:  n_state = S_F2;
            S_F2:  n_state = S_R1;
            S_R1:  n_state = S_R2;
            S_R2:  n_state = S_EX;
            S_EX: begin
                n_state = S_IDLE;
                if (top == OP_ALU && (on == ALU_ADD || on == ALU_SUB || on == ALU_SHR
                        || on == ALU_SBN || on == ALU_SHL)) begin
                    n_state = S_FLG;
                end else if (top == OP_DRW && on != 4'h0) begin
                    n_state = S_DR;
                end else if (top == OP_MISC && nn == NN_BCD) begin
                    n_state = S_BCD;
                end else if (top == OP_MISC && nn == NN_DUMP) begin
                    n_state = S_STR;
                end else if (top == OP_MISC && nn == NN_FILL) begin
                    n_state = S_LDR;
                end
            end
            S_FLG: n_state = S_IDLE;
            S_DR:  n_state = S_DW;
            S_DW:  n_state = (r_cnt == on - 4'd1) ? S_DF : S_DR;
            S_DF:  n_state = S_IDLE;
            S_BCD: n_state = (r_cnt == 4'd2) ? S_IDLE : S_BCD;
            S_STR: n_state = S_STW;
            S_STW: n_state = (r_cnt == ox) ? S_IDLE : S_STR;
            S_LDR: n_state = S_LDW;
            S_LDW: n_state = (r_cnt == ox) ? S_IDLE : S_LDR;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        n_i = r_i;
        n_sp = r_sp;
        n_halt = r_halt;
        n_op = r_op;
        n_vx = r_vx;
        n_vy = r_vy;
        n_flag = r_flag;
        n_cnt = r_cnt;
        n_hit = r_hit;
        n_vvld = r_vvld;
        n_svld = r_svld;
        n_kvld = r_kvld;
        fin = 1'b0;
        n_o_pc = r_pc;
        n_o_op = 16'h0000;
        n_o_st = r_halt ? ST_HALTED : ST_OK;
        n_o_rv = 8'h00;
        pm_we = 1'b0;
        pm_wa = i_address;
        pm_wd = i_data;
        pm_ra = r_pc;
        vr_we = 1'b0;
        vr_wa = ox;
        vr_wd = 8'h00;
        vr_ra = 4'h0;
        sc_we = 1'b0;
        sc_wa = draw_row;
        sc_wd = sval ^ mask;
        sc_ra = draw_row;
        sk_we = 1'b0;
        sk_wa = r_sp;
        sk_wd = r_pc;
        sk_ra = sp_dec;

        unique case (r_state)
            S_IDLE: begin
                sc_ra = i_address[10:6];
                vr_ra = i_address[3:0];
                if (accept) begin
                    if (i_kind == K_LOAD) begin
                        pm_we = 1'b1;
                        fin = 1'b1;
                    end else if (i_kind == K_STEP && r_halt) begin
                        fin = 1'b1;
                    end
                end
            end
            S_RDW: begin
                fin = 1'b1;
                if (r_kind == K_PIX) begin
                    n_o_rv = {7'd0, sval[r_addr[5:0]]};
                end else begin
                    n_o_rv = vval;
                end
            end
            S_F1: begin
                n_op[15:8] = pm_rd;
                pm_ra = r_pc + 12'd1;
            end
            S_F2: begin
                n_op[7:0] = pm_rd;
                vr_ra = ox;
            end
            S_R1: begin
                n_vx = vval;
                vr_ra = (top == OP_JPV) ? 4'h0 : oy;
            end
            S_R2: begin
                n_vy = vval;
            end
            S_EX: begin
                n_o_op = r_op;
                n_o_st = ST_OK;
                n_pc = pc2;
                n_cnt = 4'd0;
                n_hit = 1'b0;
                fin = 1'b1;
                vr_wa = ox;
                unique case (top)
                    OP_SYS: begin
                        if (nn == NN_CLS) begin
                            n_svld = '0;
                        end else if (nn == NN_RET && ox == 4'h0) begin
                            n_sp = sp_dec;
                            n_pc = (r_krv ? sk_rd : '0) + 12'd2;
                        end
                    end
                    OP_JP: begin
                        if (r_quit && nnn == r_pc) begin
                            n_halt = 1'b1;
                            n_pc = r_pc;
                            n_o_st = ST_LOOP;
                        end else begin
                            n_pc = nnn;
                        end
                    end
                    OP_CALL: begin
                        sk_we = 1'b1;
                        n_kvld[r_sp] = 1'b1;
                        n_sp = sp_inc;
                        n_pc = nnn;
                    end
                    OP_SEI:  if (r_vx == nn) n_pc = pc4;
                    OP_SNEI: if (r_vx != nn) n_pc = pc4;
                    OP_SER:  if (r_vx == r_vy) n_pc = pc4;
                    OP_SNER: if (r_vx != r_vy) n_pc = pc4;
                    OP_LDI: begin
                        vr_we = 1'b1;
                        vr_wd = nn;
                        n_vvld[ox] = 1'b1;
                    end
                    OP_ADDI: begin
                        vr_we = 1'b1;
                        vr_wd = r_vx + nn;
                        n_vvld[ox] = 1'b1;
                    end
                    OP_ALU: begin
                        vr_we = 1'b1;
                        n_vvld[ox] = 1'b1;
                        unique case (on)
                            ALU_MOV: vr_wd = r_vy;
                            ALU_OR:  vr_wd = r_vx | r_vy;
                            ALU_AND: vr_wd = r_vx & r_vy;
                            ALU_XOR: vr_wd = r_vx ^ r_vy;
                            ALU_ADD: begin
                                vr_wd = sum9[7:0];
                                n_flag = {7'd0, sum9[8]};
                            end
                            ALU_SUB: begin
                                vr_wd = r_vx - r_vy;
                                n_flag = {7'd0, r_vx >= r_vy};
                            end
                            ALU_SHR: begin
                                vr_wd = {1'b0, r_vx[7:1]};
                                n_flag = {7'd0, r_vx[0]};
                            end
                            ALU_SBN: begin
                                vr_wd = r_vy - r_vx;
                                n_flag = {7'd0, r_vy >= r_vx};
                            end
                            ALU_SHL: begin
                                vr_wd = {r_vx[6:0], 1'b0};
                                n_flag = {7'd0, r_vx[7]};
                            end
                            default: begin
                                vr_we = 1'b0;
                                n_vvld = r_vvld;
                            end
                        endcase
                        if (n_state == S_FLG) begin
                            fin = 1'b0;
                            n_pc = r_pc;
                        end
                    end
                    OP_SETI: n_i = nnn;
                    OP_JPV: n_pc = {4'h0, r_vy} + nnn;
                    OP_DRW: begin
                        if (on == 4'h0) begin
                            vr_we = 1'b1;
                            vr_wa = REG_F;
                            vr_wd = 8'h00;
                            n_vvld[REG_F] = 1'b1;
                        end else begin
                            fin = 1'b0;
                            n_pc = r_pc;
                        end
                    end
                    OP_MISC: begin
                        if (nn == NN_ADDI) begin
                            n_i = r_i + {4'h0, r_vx};
                        end else if (nn == NN_BCD || nn == NN_DUMP || nn == NN_FILL) begin
                            fin = 1'b0;
                            n_pc = r_pc;
                        end
                    end
                    default: begin
                        n_halt = 1'b1;
                        n_pc = r_pc;
                        n_o_st = ST_BAD;
                    end
                endcase
                n_o_pc = n_pc;
            end
            S_FLG: begin
                vr_we = 1'b1;
                vr_wa = REG_F;
                vr_wd = r_flag;
                n_vvld[REG_F] = 1'b1;
                n_pc = pc2;
                fin = 1'b1;
                n_o_op = r_op;
                n_o_st = ST_OK;
                n_o_pc = pc2;
            end
            S_DR: begin
                pm_ra = i_off;
                sc_ra = draw_row;
            end
            S_DW: begin
                sc_we = 1'b1;
                n_svld[draw_row] = 1'b1;
                n_hit = r_hit | (|(sval & mask));
                n_cnt = r_cnt + 4'd1;
            end
            S_DF: begin
                vr_we = 1'b1;
                vr_wa = REG_F;
                vr_wd = {7'd0, r_hit};
                n_vvld[REG_F] = 1'b1;
                n_pc = pc2;
                fin = 1'b1;
                n_o_op = r_op;
                n_o_st = ST_OK;
                n_o_pc = pc2;
            end
            S_BCD: begin
                pm_we = 1'b1;
                pm_wa = i_off;
                priority case (r_cnt)
                    4'd0: pm_wd = hund;
                    4'd1: pm_wd = tens;
                    default: pm_wd = ones;
                endcase
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) begin
                    n_pc = pc2;
                    fin = 1'b1;
                    n_o_op = r_op;
                    n_o_st = ST_OK;
                    n_o_pc = pc2;
                end
            end
            S_STR: begin
                vr_ra = r_cnt;
            end
            S_STW: begin
                pm_we = 1'b1;
                pm_wa = i_off;
                pm_wd = vval;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == ox) begin
                    n_pc = pc2;
                    fin = 1'b1;
                    n_o_op = r_op;
                    n_o_st = ST_OK;
                    n_o_pc = pc2;
                end
            end
            S_LDR: begin
                pm_ra = i_off;
            end
            S_LDW: begin
                vr_we = 1'b1;
                vr_wa = r_cnt;
                vr_wd = pm_rd;
                n_vvld[r_cnt] = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == ox) begin
                    n_pc = pc2;
                    fin = 1'b1;
                    n_o_op = r_op;
                    n_o_st = ST_OK;
                    n_o_pc = pc2;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= START_PC;
            r_i <= '0;
            r_sp <= '0;
            r_halt <= 1'b0;
            r_quit <= 1'b0;
            r_vvld <= '0;
            r_svld <= '0;
            r_kvld <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            r_i <= n_i;
            r_sp <= n_sp;
            r_halt <= n_halt;
            r_vvld <= n_vvld;
            r_svld <= n_svld;
            r_kvld <= n_kvld;
            if (i_cfg_wr_en) begin
                r_quit <= i_cfg_wr_data;
            end
            if (fin) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_addr <= i_address;
        end
        r_op <= n_op;
        r_vx <= n_vx;
        r_vy <= n_vy;
        r_flag <= n_flag;
        r_cnt <= n_cnt;
        r_hit <= n_hit;
        r_vrv <= r_vvld[vr_ra];
        r_srv <= r_svld[sc_ra];
        r_krv <= r_kvld[sk_ra];
        if (fin) begin
            r_o_pc <= n_o_pc;
            r_o_op <= n_o_op;
            r_o_st <= n_o_st;
            r_o_rv <= n_o_rv;
        end
    end

endmodule
